>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants for the I2C master byte engine
// Holds command codes, operation enum, item and result records.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int BYTE_BITS = 8;
  localparam int TICK_W    = 16;
  localparam int PHASE_W   = 2;
  localparam int BIT_W     = 4;

  localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd5;

  // Raw command codes on the input channel
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  // Classified tick item handed from front to back
  typedef struct packed {
    op_e                  op;
    logic [BYTE_BITS-1:0] write_byte;
    logic                 send_ack;
    logic                 sda_in;
  } item_t;

  // One result per tick
  typedef struct packed {
    logic                 scl_level;
    logic                 sda_level;
    logic                 sda_drive;
    logic                 busy_res;
    logic                 done_res;
    logic                 nack_seen;
    logic [BYTE_BITS-1:0] read_byte;
  } result_t;

endpackage

>>> rtl/i2cm_fifo.sv
// ----------------------------------------------------------------------------
// i2cm_fifo: two-entry queue
// Decouples producer and consumer; full and empty come from a registered count.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front: input side of the byte engine
// Accepts tick items, classifies the command code and queues the item.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           cmd_i,
  input  logic [BYTE_BITS-1:0] write_byte_i,
  input  logic                 send_ack_i,
  input  logic                 sda_in_i,
  input  logic                 item_pop_i,
  output logic                 item_valid_o,
  output item_t                item_o
);

  item_t            item_in;
  logic             full;
  logic [$bits(item_t)-1:0] item_raw;

  // Decode the command; unknown codes become no operation
  always_comb begin
    item_in.write_byte = write_byte_i;
    item_in.send_ack   = send_ack_i;
    item_in.sda_in     = sda_in_i;
    unique case (cmd_i)
      CMD_START: item_in.op = OP_START;
      CMD_STOP:  item_in.op = OP_STOP;
      CMD_WRITE: item_in.op = OP_WRITE;
      CMD_READ:  item_in.op = OP_READ;
      default:   item_in.op = OP_IDLE;
    endcase
  end

  assign in_stall_o = full;

  i2cm_fifo #(
    .WIDTH ($bits(item_t))
  ) u_item_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (item_in),
    .full_o      (full),
    .pop_i       (item_pop_i),
    .valid_o     (item_valid_o),
    .pop_data_o  (item_raw)
  );

  assign item_o = item_t'(item_raw);

endmodule

>>> rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine: back side of the byte engine
// Steps the command phases, ending each when its tick count reaches the half period, and drives the bus pins.
// ----------------------------------------------------------------------------
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [TICK_W-1:0] cfg_data_i,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output result_t           res_o
);

  logic [TICK_W-1:0]    hp_q;
  logic [TICK_W-1:0]    hp_eff;
  op_e                  op_q, op_d;
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [TICK_W:0]      tick_sum;
  logic [BYTE_BITS-1:0] shift_q, shift_d;
  logic                 ack_q, ack_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 oe_q, oe_d;
  logic                 nack_q, nack_d;
  logic [BYTE_BITS-1:0] rbyte_q, rbyte_d;
  logic                 fire, apply, done, finish;
  logic                 in_byte_q, in_byte_d;

  assign fire       = item_valid_i && !res_full_i;
  assign item_pop_o = fire;
  assign res_push_o = fire;
  assign hp_eff     = (hp_q == '0) ? TICK_W'(1) : hp_q;
  assign tick_sum   = {1'b0, tick_q} + 1'b1;
  assign in_byte_q  = (bit_q < BIT_W'(BYTE_BITS));
  assign in_byte_d  = (bit_d < BIT_W'(BYTE_BITS));

  // Next state: accept commands when idle, end phases when the count expires
  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    ack_d   = ack_q;
    nack_d  = nack_q;
    rbyte_d = rbyte_q;
    apply   = 1'b0;
    done    = 1'b0;
    finish  = 1'b0;
    if (fire) begin
      if (op_q == OP_IDLE) begin
        if (item_i.op != OP_IDLE) begin
          op_d    = item_i.op;
          phase_d = '0;
          bit_d   = '0;
          tick_d  = '0;
          if (item_i.op == OP_WRITE) begin
            shift_d = item_i.write_byte;
          end
          if (item_i.op == OP_READ) begin
            shift_d = '0;
            ack_d   = item_i.send_ack;
          end
          apply = 1'b1;
        end
      end else if (tick_sum >= {1'b0, hp_eff}) begin
        tick_d = '0;
        unique case (op_q)
          OP_START: begin
            if (phase_q < PHASE_W'(3)) phase_d = phase_q + 1'b1;
            else finish = 1'b1;
          end
          OP_STOP: begin
            if (phase_q < PHASE_W'(2)) phase_d = phase_q + 1'b1;
            else finish = 1'b1;
          end
          OP_WRITE: begin
            if (in_byte_q) begin
              if (phase_q == '0) begin
                phase_d = PHASE_W'(1);
              end else begin
                shift_d = {shift_q[BYTE_BITS-2:0], 1'b0};
                bit_d   = bit_q + 1'b1;
                phase_d = '0;
              end
            end else if (phase_q == '0) begin
              nack_d  = item_i.sda_in;
              phase_d = PHASE_W'(1);
            end else begin
              finish = 1'b1;
            end
          end
          OP_READ: begin
            if (in_byte_q) begin
              if (phase_q == '0) begin
                shift_d = {shift_q[BYTE_BITS-2:0], item_i.sda_in};
                phase_d = PHASE_W'(1);
              end else begin
                bit_d   = bit_q + 1'b1;
                phase_d = '0;
              end
            end else if (phase_q < PHASE_W'(2)) begin
              phase_d = phase_q + 1'b1;
            end else begin
              rbyte_d = shift_q;
              finish  = 1'b1;
            end
          end
          default: finish = 1'b1;
        endcase
        if (finish) begin
          op_d    = OP_IDLE;
          phase_d = '0;
          bit_d   = '0;
          done    = 1'b1;
        end else begin
          apply = 1'b1;
        end
      end else begin
        tick_d = tick_sum[TICK_W-1:0];
      end
    end
  end

  // Pin drivers for the phase just entered
  always_comb begin
    scl_d = scl_q;
    sda_d = sda_q;
    oe_d  = oe_q;
    if (apply) begin
      unique case (op_d)
        OP_START: begin
          unique case (phase_d)
            2'd0: begin
              sda_d = 1'b1;
              oe_d  = 1'b1;
            end
            2'd1:    scl_d = 1'b1;
            2'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
        end
        OP_STOP: begin
          if (phase_d == '0) begin
            oe_d  = 1'b1;
            sda_d = 1'b0;
          end else if (phase_d == PHASE_W'(1)) begin
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        OP_WRITE: begin
          if (in_byte_d) begin
            if (phase_d == '0) begin
              sda_d = shift_d[BYTE_BITS-1];
              oe_d  = 1'b1;
              scl_d = 1'b1;
            end else begin
              scl_d = 1'b0;
            end
          end else if (phase_d == '0) begin
            oe_d  = 1'b0;
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
            oe_d  = 1'b1;
          end
        end
        OP_READ: begin
          if (in_byte_d) begin
            if (phase_d == '0) begin
              oe_d  = 1'b0;
              scl_d = 1'b1;
            end else begin
              scl_d = 1'b0;
            end
          end else if (phase_d == '0) begin
            oe_d  = 1'b1;
            sda_d = !ack_d;
          end else if (phase_d == PHASE_W'(1)) begin
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        default: scl_d = scl_q;
      endcase
    end
  end

  // Assemble the result from the updated state
  always_comb begin
    res_o.scl_level = scl_d;
    res_o.sda_level = sda_d;
    res_o.sda_drive = oe_d;
    res_o.busy_res  = (op_d != OP_IDLE);
    res_o.done_res  = done;
    res_o.nack_seen = nack_d;
    res_o.read_byte = rbyte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q    <= HALF_PERIOD_RESET;
      op_q    <= OP_IDLE;
      phase_q <= '0;
      bit_q   <= '0;
      tick_q  <= '0;
      shift_q <= '0;
      ack_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      oe_q    <= 1'b1;
      nack_q  <= 1'b0;
      rbyte_q <= '0;
    end else begin
      if (cfg_we_i) begin
        hp_q <= cfg_data_i;
      end
      op_q    <= op_d;
      phase_q <= phase_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      ack_q   <= ack_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      oe_q    <= oe_d;
      nack_q  <= nack_d;
      rbyte_q <= rbyte_d;
    end
  end

endmodule

>>> rtl/i2c_master_byte_engine_top.sv
// Path: a tick item is registered in the input queue, the engine forms its result
// combinationally and pushes it into the result queue, which feeds the output.
// Throughput: one tick item per cycle unless the result queue is full or the output is stalled.
// Reset: asynchronous active low; bus released (SCL, SDA high, driven), idle,
// half period 5 ticks; both queues empty.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_top: I2C master byte engine
// Front queue of tick items, phase engine, and result queue.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_top
  import i2cm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [TICK_W-1:0]    cfg_half_period_ticks_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           cmd_i,
  input  logic [BYTE_BITS-1:0] write_byte_i,
  input  logic                 send_ack_i,
  input  logic                 sda_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 scl_level_o,
  output logic                 sda_level_o,
  output logic                 sda_drive_o,
  output logic                 busy_res_o,
  output logic                 done_res_o,
  output logic                 nack_seen_o,
  output logic [BYTE_BITS-1:0] read_byte_o
);

  logic    item_valid, item_pop;
  item_t   item;
  logic    res_full, res_push;
  result_t res_in, res_out;
  logic [$bits(result_t)-1:0] res_raw;

  assign cfg_ready_o = 1'b1;

  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .write_byte_i (write_byte_i),
    .send_ack_i   (send_ack_i),
    .sda_in_i     (sda_in_i),
    .item_pop_i   (item_pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  i2cm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_half_period_ticks_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  // Hold results until the consumer takes the transfer
  i2cm_fifo #(
    .WIDTH ($bits(result_t))
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res_in),
    .full_o      (res_full),
    .pop_i       (!out_stall_i),
    .valid_o     (out_valid_o),
    .pop_data_o  (res_raw)
  );

  assign res_out     = result_t'(res_raw);
  assign scl_level_o = res_out.scl_level;
  assign sda_level_o = res_out.sda_level;
  assign sda_drive_o = res_out.sda_drive;
  assign busy_res_o  = res_out.busy_res;
  assign done_res_o  = res_out.done_res;
  assign nack_seen_o = res_out.nack_seen;
  assign read_byte_o = res_out.read_byte;

endmodule

>>> rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker: port-level checks for the I2C master byte engine
// Watches the result channel over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic sda_drive_o,
  input logic busy_res_o,
  input logic done_res_o
);

  // Hold a stalled result transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result transfer dropped while stalled");

  // Drop busy on the completing tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("busy still set on done tick");

  // Release SDA only inside a byte command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sda_drive_o |-> busy_res_o)
    else $error("SDA released while idle");

  // Drive SDA again once a command completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> sda_drive_o)
    else $error("SDA not driven at command completion");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_checker (.*);
